[rtl/dds_pkg.sv]
// Shared types, codes and constants for the display draw byte sequencer.
package dds_pkg;

    // Screen size in pixels
    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 128;

    // Glyph geometry
    localparam int GLYPH_COLS = 6;
    localparam int GLYPH_ROWS = 8;
    localparam int GLYPH_BITS = GLYPH_COLS * GLYPH_ROWS;
    localparam logic [7:0] GLYPH_ROW_END = 8'h7F;

    // Action codes of an input item
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_FILL  = 2'd1;
    localparam logic [1:0] ACT_PIXEL = 2'd2;
    localparam logic [1:0] ACT_GLYPH = 2'd3;

    // Header steps; the last code is the pixel phase
    localparam logic [2:0] STEP_COL_CMD   = 3'd0;
    localparam logic [2:0] STEP_COL_START = 3'd1;
    localparam logic [2:0] STEP_COL_END   = 3'd2;
    localparam logic [2:0] STEP_ROW_CMD   = 3'd3;
    localparam logic [2:0] STEP_ROW_START = 3'd4;
    localparam logic [2:0] STEP_ROW_END   = 3'd5;
    localparam logic [2:0] STEP_MEM_CMD   = 3'd6;
    localparam logic [2:0] STEP_PIXEL     = 3'd7;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_WIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_WR  = 2'd2;

    // Reset values of the command registers
    localparam logic [7:0] RST_COL_WIN = 8'd21;
    localparam logic [7:0] RST_ROW_WIN = 8'd117;
    localparam logic [7:0] RST_MEM_WR  = 8'd92;

    typedef struct packed {
        logic [7:0] cmd_column_window;
        logic [7:0] cmd_row_window;
        logic [7:0] cmd_write_memory;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
        logic [7:0]  rect_width;
        logic [7:0]  rect_height;
        logic [15:0] fore_color;
        logic [15:0] back_color;
        logic [47:0] glyph_bits;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       last;
    } t_result;

endpackage

[rtl/dds_in_if.sv]
// Input item channel: start and tick items with their operands.
interface dds_in_if;
    import dds_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [7:0]  rect_width;
    logic [7:0]  rect_height;
    logic [15:0] fore_color;
    logic [15:0] back_color;
    logic [47:0] glyph_bits;

    modport source (
        output valid, action, pos_x, pos_y, rect_width, rect_height,
               fore_color, back_color, glyph_bits,
        input  ready
    );
    modport sink (
        input  valid, action, pos_x, pos_y, rect_width, rect_height,
               fore_color, back_color, glyph_bits,
        output ready
    );
endinterface

[rtl/dds_out_if.sv]
// Result item channel: one byte with its data/command flag and end marker.
interface dds_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;

    modport source (output valid, out_byte, is_data, last, input ready);
    modport sink   (input valid, out_byte, is_data, last, output ready);
endinterface

[rtl/dds_cfg_if.sv]
// Configuration write channel: register index and write data.
interface dds_cfg_if;
    import dds_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [7:0]           wr_data;

    modport source (output valid, wr_index, wr_data, input ready);
    modport sink   (input valid, wr_index, wr_data, output ready);
endinterface

[rtl/dds_cfg_regs.sv]
// Command byte registers written through the configuration channel.
module dds_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dds_cfg_if.sink       i_cfg,
    output dds_pkg::t_cfg o_cfg
);
    import dds_pkg::*;

    t_cfg r_cfg;

    // Writes are always taken; unknown indexes are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cmd_column_window <= RST_COL_WIN;
            r_cfg.cmd_row_window    <= RST_ROW_WIN;
            r_cfg.cmd_write_memory  <= RST_MEM_WR;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.wr_index)
                CFG_COL_WIN: r_cfg.cmd_column_window <= i_cfg.wr_data;
                CFG_ROW_WIN: r_cfg.cmd_row_window    <= i_cfg.wr_data;
                CFG_MEM_WR:  r_cfg.cmd_write_memory  <= i_cfg.wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

[rtl/dds_seq.sv]
// Job state and byte selection: latches a start, yields one byte per tick during a job.
module dds_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  dds_pkg::t_item   i_item,
    input  dds_pkg::t_cfg    i_cfg,
    output logic             o_res_valid,
    output dds_pkg::t_result o_res
);
    import dds_pkg::*;

    // Control state
    logic       r_busy, n_busy;
    logic [1:0] r_draw_mode, n_draw_mode;
    logic [2:0] r_header_step, n_header_step;
    logic       r_low_half_next, n_low_half_next;
    logic [7:0] r_col_index, n_col_index;
    logic [7:0] r_row_index, n_row_index;
    // Job operands
    logic [7:0]  r_col_start, n_col_start;
    logic [7:0]  r_col_end, n_col_end;
    logic [7:0]  r_row_start, n_row_start;
    logic [7:0]  r_row_end, n_row_end;
    logic [15:0] r_fg_latch, n_fg_latch;
    logic [15:0] r_bg_latch, n_bg_latch;
    logic [47:0] r_glyph_latch, n_glyph_latch;

    logic [8:0]  sum_x, sum_y;
    logic [7:0]  fill_col_end, fill_row_end;
    logic        on_screen;
    logic        fill_empty;
    logic [5:0]  bit_idx;
    logic        glyph_fg;
    logic [15:0] color;
    logic [7:0]  last_col, last_row;

    // Rectangle clipping to the screen edges
    assign sum_x = {1'b0, i_item.pos_x} + {1'b0, i_item.rect_width};
    assign sum_y = {1'b0, i_item.pos_y} + {1'b0, i_item.rect_height};
    assign fill_col_end = (sum_x > 9'(SCREEN_WIDTH)) ? 8'(SCREEN_WIDTH - 1)
                                                    : 8'(sum_x - 9'd1);
    assign fill_row_end = (sum_y > 9'(SCREEN_HEIGHT)) ? 8'(SCREEN_HEIGHT - 1)
                                                     : 8'(sum_y - 9'd1);
    assign on_screen = ({1'b0, i_item.pos_x} < 9'(SCREEN_WIDTH)) &&
                       ({1'b0, i_item.pos_y} < 9'(SCREEN_HEIGHT));

    assign fill_empty = (8'(r_col_end + 8'd1) == r_col_start) ||
                        (8'(r_row_end + 8'd1) == r_row_start);

    // Pixel color and end of the scan
    assign bit_idx  = {r_col_index[2:0], r_row_index[2:0]};
    assign glyph_fg = (bit_idx < 6'(GLYPH_BITS)) ? r_glyph_latch[bit_idx] : 1'b1;

    always_comb begin
        color    = r_fg_latch;
        last_col = 8'd0;
        last_row = 8'd0;
        case (r_draw_mode)
            ACT_GLYPH: begin
                if (!glyph_fg) color = r_bg_latch;
                last_col = 8'(GLYPH_COLS - 1);
                last_row = 8'(GLYPH_ROWS - 1);
            end
            ACT_FILL: begin
                last_col = 8'(r_col_end - r_col_start);
                last_row = 8'(r_row_end - r_row_start);
            end
            default: ;
        endcase
    end

    // Next state and result
    always_comb begin
        n_busy          = r_busy;
        n_draw_mode     = r_draw_mode;
        n_header_step   = r_header_step;
        n_low_half_next = r_low_half_next;
        n_col_index     = r_col_index;
        n_row_index     = r_row_index;
        n_col_start     = r_col_start;
        n_col_end       = r_col_end;
        n_row_start     = r_row_start;
        n_row_end       = r_row_end;
        n_fg_latch      = r_fg_latch;
        n_bg_latch      = r_bg_latch;
        n_glyph_latch   = r_glyph_latch;
        o_res_valid     = 1'b0;
        o_res           = '0;

        if (i_accept && i_item.action != ACT_TICK) begin
            // Start item: used only while idle and, unless it is a glyph, inside the screen
            if (!r_busy && (i_item.action == ACT_GLYPH || on_screen)) begin
                n_col_start = i_item.pos_x;
                n_row_start = i_item.pos_y;
                case (i_item.action)
                    ACT_FILL: begin
                        n_col_end = fill_col_end;
                        n_row_end = fill_row_end;
                    end
                    ACT_PIXEL: begin
                        n_col_end = 8'(SCREEN_WIDTH - 1);
                        n_row_end = 8'(SCREEN_HEIGHT - 1);
                    end
                    default: begin
                        n_col_end = 8'(i_item.pos_x + 8'(GLYPH_COLS - 1));
                        n_row_end = GLYPH_ROW_END;
                    end
                endcase
                n_fg_latch      = i_item.fore_color;
                n_bg_latch      = i_item.back_color;
                n_glyph_latch   = i_item.glyph_bits;
                n_draw_mode     = i_item.action;
                n_header_step   = STEP_COL_CMD;
                n_col_index     = 8'd0;
                n_row_index     = 8'd0;
                n_low_half_next = 1'b0;
                n_busy          = 1'b1;
            end
        end else if (i_accept && r_busy) begin
            // Tick item: one byte of the running job
            o_res_valid = 1'b1;
            if (r_header_step != STEP_PIXEL) begin
                n_header_step = 3'(r_header_step + 3'd1);
            end
            unique case (r_header_step)
                STEP_COL_CMD:   o_res = '{i_cfg.cmd_column_window, 1'b0, 1'b0};
                STEP_COL_START: o_res = '{r_col_start, 1'b1, 1'b0};
                STEP_COL_END:   o_res = '{r_col_end, 1'b1, 1'b0};
                STEP_ROW_CMD:   o_res = '{i_cfg.cmd_row_window, 1'b0, 1'b0};
                STEP_ROW_START: o_res = '{r_row_start, 1'b1, 1'b0};
                STEP_ROW_END:   o_res = '{r_row_end, 1'b1, 1'b0};
                STEP_MEM_CMD: begin
                    // an empty rectangle ends after its header
                    if (r_draw_mode == ACT_FILL && fill_empty) begin
                        o_res  = '{i_cfg.cmd_write_memory, 1'b0, 1'b1};
                        n_busy = 1'b0;
                    end else begin
                        o_res = '{i_cfg.cmd_write_memory, 1'b0, 1'b0};
                    end
                end
                STEP_PIXEL: begin
                    if (!r_low_half_next) begin
                        o_res           = '{color[15:8], 1'b1, 1'b0};
                        n_low_half_next = 1'b1;
                    end else begin
                        n_low_half_next = 1'b0;
                        if (r_col_index == last_col && r_row_index == last_row) begin
                            o_res  = '{color[7:0], 1'b1, 1'b1};
                            n_busy = 1'b0;
                        end else begin
                            o_res = '{color[7:0], 1'b1, 1'b0};
                            if (r_col_index >= last_col) begin
                                n_col_index = 8'd0;
                                n_row_index = 8'(r_row_index + 8'd1);
                            end else begin
                                n_col_index = 8'(r_col_index + 8'd1);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy          <= 1'b0;
            r_draw_mode     <= ACT_TICK;
            r_header_step   <= STEP_COL_CMD;
            r_low_half_next <= 1'b0;
            r_col_index     <= 8'd0;
            r_row_index     <= 8'd0;
        end else begin
            r_busy          <= n_busy;
            r_draw_mode     <= n_draw_mode;
            r_header_step   <= n_header_step;
            r_low_half_next <= n_low_half_next;
            r_col_index     <= n_col_index;
            r_row_index     <= n_row_index;
        end
    end

    // Job operands, only read while busy
    always_ff @(posedge i_clk) begin
        r_col_start   <= n_col_start;
        r_col_end     <= n_col_end;
        r_row_start   <= n_row_start;
        r_row_end     <= n_row_end;
        r_fg_latch    <= n_fg_latch;
        r_bg_latch    <= n_bg_latch;
        r_glyph_latch <= n_glyph_latch;
    end

`ifndef SYNTHESIS
    // A running job always has a drawing mode
    a_busy_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_draw_mode != ACT_TICK))
        else $error("busy without drawing mode");

    // Glyph scan stays inside the 6x8 cell
    a_glyph_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_draw_mode == ACT_GLYPH && r_header_step == STEP_PIXEL)
        |-> (r_col_index < 8'(GLYPH_COLS) && r_row_index < 8'(GLYPH_ROWS)))
        else $error("glyph scan out of range");

    // The final byte ends the job
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |=> !r_busy)
        else $error("job still busy after last byte");

    // A byte is only produced for a job that was running
    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> r_busy)
        else $error("byte produced while idle");
`endif
endmodule

[rtl/display_draw_byte_sequencer_top.sv]
// A tick item's byte appears in the output register in the cycle after the tick is accepted.
// Throughput: one item per cycle unless the output stalls; a new item is taken while a byte
// waits if it is taken in the same cycle; the single output register stage sets the rate.
// Start items produce no byte; each tick during a job produces exactly one byte.
// Reset (synchronous, active low) idles the job, empties the output register and restores
// the command registers; the block takes items from the first cycle after reset.
module display_draw_byte_sequencer_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dds_in_if.sink   i_in,
    dds_cfg_if.sink  i_cfg,
    dds_out_if.source o_out
);
    import dds_pkg::*;

    t_cfg    cfg;
    t_item   item;
    t_result res;
    logic    res_valid;
    logic    in_accept;

    logic    r_out_valid;
    t_result r_out;

    dds_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Input payload gathered into one item
    assign item = '{i_in.action, i_in.pos_x, i_in.pos_y, i_in.rect_width,
                    i_in.rect_height, i_in.fore_color, i_in.back_color,
                    i_in.glyph_bits};

    // Take an item whenever the output register is free or being emptied
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;

    dds_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_item      (item),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= res_valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out.out_byte;
    assign o_out.is_data  = r_out.is_data;
    assign o_out.last     = r_out.last;

`ifndef SYNTHESIS
    // A waiting byte is never dropped by a new item
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !in_accept)
        else $error("item accepted over a waiting byte");

    // A produced byte is visible in the next cycle
    a_res_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && res_valid) |=> r_out_valid)
        else $error("byte lost on its way to the output");

    // Output register empties only through a handshake
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> r_out_valid)
        else $error("waiting byte vanished");
`endif
endmodule
